// ===== rtl/core/btmx_pkg.sv =====
// Shared widths, codes and state encoding for the binary trie min-xor match core.
package btmx_pkg;

   localparam int KEY_W             = 32;
   localparam int OP_W              = 2;
   localparam int STATUS_W          = 2;
   localparam int CFG_W             = 6;
   localparam int LVL_W             = 5;
   localparam int MAX_KEY_BITS      = 32;
   localparam int DEF_NODE_CAPACITY = 4096;
   localparam int DEF_COUNT_WIDTH   = 16;

   typedef enum logic [OP_W-1:0] {
      OP_INSERT = 2'd0,
      OP_DELETE = 2'd1,
      OP_QUERY  = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK     = 2'd0,
      STATUS_EMPTY  = 2'd1,
      STATUS_ABSENT = 2'd2,
      STATUS_FULL   = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'd0,
      ST_CHECK = 3'd1,
      ST_ROOM  = 3'd2,
      ST_WRITE = 3'd3,
      ST_DONE  = 3'd4
   } state_type;

endpackage

// ===== rtl/core/btmx_req_if.sv =====
// Request channel: operation and key with valid/ready handshake.
interface btmx_req_if;
   logic                        valid;
   logic                        ready;
   logic [btmx_pkg::OP_W-1:0]   operation;
   logic [btmx_pkg::KEY_W-1:0]  key;

   modport source (output valid, output operation, output key, input ready);
   modport sink   (input valid, input operation, input key, output ready);
endinterface

// ===== rtl/core/btmx_rsp_if.sv =====
// Response channel: partner, zero mask and status with valid/ready handshake.
interface btmx_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [btmx_pkg::KEY_W-1:0]     partner;
   logic [btmx_pkg::KEY_W-1:0]     zero_mask;
   logic [btmx_pkg::STATUS_W-1:0]  status;

   modport source (output valid, output partner, output zero_mask, output status, input ready);
   modport sink   (input valid, input partner, input zero_mask, input status, output ready);
endinterface

// ===== rtl/core/binary_trie_min_xor_match_core.sv =====
// Binary xor trie with per-edge counts: insert, delete, nearest-by-xor query, clear.
//
// One operation at a time walks the trie MSB first through a single node memory,
// one trie level per cycle (registered read of the next node while the current one
// is evaluated and written back). With depth D = key_bits clamped to 1..32, an
// insert or delete runs a check walk, one capacity step, an update walk and a
// result step, a query a check walk and a result step, and a clear the result
// step alone; failed checks end the operation early. The result sits in an output
// register, so a pending response does not hold up the next request until the
// following result is ready. Writing key_bits empties the set.
module binary_trie_min_xor_match_core #(
   parameter int NODE_CAPACITY = btmx_pkg::DEF_NODE_CAPACITY,
   parameter int COUNT_WIDTH   = btmx_pkg::DEF_COUNT_WIDTH
) (
   input  logic                        clock,
   input  logic                        reset,
   btmx_req_if.sink                    req_chan,
   btmx_rsp_if.source                  rsp_chan,
   input  logic                        csr_wr_en,
   input  logic [btmx_pkg::CFG_W-1:0]  csr_wr_data
);

   localparam int NW    = $clog2(NODE_CAPACITY);
   localparam int NUW   = $clog2(NODE_CAPACITY + 1);
   localparam int SUM_W = NUW + 1;
   localparam logic [SUM_W-1:0] CAP_SUM = SUM_W'(NODE_CAPACITY);

   typedef struct packed {
      logic [NW-1:0]          link1;
      logic [NW-1:0]          link0;
      logic [COUNT_WIDTH-1:0] cnt1;
      logic [COUNT_WIDTH-1:0] cnt0;
   } node_type;

   node_type mem [NODE_CAPACITY];
   node_type rd_data_ff;
   logic             mem_rd_en;
   logic [NW-1:0]    mem_rd_addr;
   logic             mem_we;
   logic [NW-1:0]    mem_wr_addr;
   node_type         mem_wr_data;

   btmx_pkg::state_type  state_ff, state_in;
   btmx_pkg::op_type     op_ff, op_in;
   btmx_pkg::status_type status_ff, status_in;
   logic [btmx_pkg::KEY_W-1:0] key_ff, key_in;
   logic [btmx_pkg::KEY_W-1:0] partner_ff, partner_in;
   logic [btmx_pkg::KEY_W-1:0] zmask_ff, zmask_in;
   logic [btmx_pkg::LVL_W-1:0] lvl_ff, lvl_in;
   logic [NW-1:0]              cur_ff, cur_in;
   logic                       fresh_ff, fresh_in;
   logic                       first_ff, first_in;
   logic [btmx_pkg::CFG_W-1:0] missing_ff, missing_in;
   logic [NUW-1:0]             nodes_used_ff, nodes_used_in;
   logic                       root_valid_ff, root_valid_in;
   logic [btmx_pkg::CFG_W-1:0] key_bits_ff, key_bits_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [btmx_pkg::KEY_W-1:0]    rsp_partner_ff, rsp_partner_in;
   logic [btmx_pkg::KEY_W-1:0]    rsp_zmask_ff, rsp_zmask_in;
   btmx_pkg::status_type          rsp_status_ff, rsp_status_in;

   logic [btmx_pkg::CFG_W-1:0] depth;
   logic [btmx_pkg::LVL_W-1:0] top_lvl;
   node_type                   eff;
   node_type                   upd;
   logic                       bit_b;
   logic [NW-1:0]              link_b;
   logic [NW-1:0]              link_nb;
   logic [COUNT_WIDTH-1:0]     cnt_b;
   logic                       hit;
   logic [NW-1:0]              nx;
   logic [SUM_W-1:0]           need_sum;

   always_comb begin
      if (key_bits_ff == '0) begin
         depth = btmx_pkg::CFG_W'(1);
      end else if (key_bits_ff > btmx_pkg::CFG_W'(btmx_pkg::MAX_KEY_BITS)) begin
         depth = btmx_pkg::CFG_W'(btmx_pkg::MAX_KEY_BITS);
      end else begin
         depth = key_bits_ff;
      end
   end

   assign top_lvl  = btmx_pkg::LVL_W'(depth - btmx_pkg::CFG_W'(1));
   assign eff      = (fresh_ff || (cur_ff == '0 && !root_valid_ff)) ? '0 : rd_data_ff;
   assign bit_b    = key_ff[lvl_ff];
   assign link_b   = bit_b ? eff.link1 : eff.link0;
   assign link_nb  = bit_b ? eff.link0 : eff.link1;
   assign cnt_b    = bit_b ? eff.cnt1 : eff.cnt0;
   assign hit      = (link_b != '0) && (cnt_b != '0);
   assign need_sum = SUM_W'(nodes_used_ff) + SUM_W'(missing_ff);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wr_addr] <= mem_wr_data;
      end
      if (mem_rd_en) begin
         rd_data_ff <= mem[mem_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= btmx_pkg::ST_IDLE;
         nodes_used_ff <= NUW'(1);
         root_valid_ff <= 1'b0;
         key_bits_ff   <= btmx_pkg::CFG_W'(btmx_pkg::MAX_KEY_BITS);
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         nodes_used_ff <= nodes_used_in;
         root_valid_ff <= root_valid_in;
         key_bits_ff   <= key_bits_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      status_ff      <= status_in;
      key_ff         <= key_in;
      partner_ff     <= partner_in;
      zmask_ff       <= zmask_in;
      lvl_ff         <= lvl_in;
      cur_ff         <= cur_in;
      fresh_ff       <= fresh_in;
      first_ff       <= first_in;
      missing_ff     <= missing_in;
      rsp_partner_ff <= rsp_partner_in;
      rsp_zmask_ff   <= rsp_zmask_in;
      rsp_status_ff  <= rsp_status_in;
   end

   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      status_in      = status_ff;
      key_in         = key_ff;
      partner_in     = partner_ff;
      zmask_in       = zmask_ff;
      lvl_in         = lvl_ff;
      cur_in         = cur_ff;
      fresh_in       = fresh_ff;
      first_in       = first_ff;
      missing_in     = missing_ff;
      nodes_used_in  = nodes_used_ff;
      root_valid_in  = root_valid_ff;
      key_bits_in    = key_bits_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      rsp_partner_in = rsp_partner_ff;
      rsp_zmask_in   = rsp_zmask_ff;
      rsp_status_in  = rsp_status_ff;
      mem_rd_en      = 1'b0;
      mem_rd_addr    = '0;
      mem_we         = 1'b0;
      mem_wr_addr    = cur_ff;
      upd            = eff;
      nx             = link_b;
      req_chan.ready = (state_ff == btmx_pkg::ST_IDLE);

      case (state_ff)
         btmx_pkg::ST_IDLE: begin
            if (csr_wr_en) begin
               key_bits_in   = csr_wr_data;
               nodes_used_in = NUW'(1);
               root_valid_in = 1'b0;
            end
            if (req_chan.valid) begin
               op_in      = btmx_pkg::op_type'(req_chan.operation);
               key_in     = req_chan.key;
               lvl_in     = top_lvl;
               cur_in     = '0;
               fresh_in   = 1'b0;
               first_in   = 1'b1;
               partner_in = '0;
               zmask_in   = '0;
               missing_in = '0;
               status_in  = btmx_pkg::STATUS_OK;
               if (btmx_pkg::op_type'(req_chan.operation) == btmx_pkg::OP_CLEAR) begin
                  nodes_used_in = NUW'(1);
                  root_valid_in = 1'b0;
                  state_in      = btmx_pkg::ST_DONE;
               end else begin
                  mem_rd_en   = 1'b1;
                  mem_rd_addr = '0;
                  state_in    = btmx_pkg::ST_CHECK;
               end
            end
         end

         btmx_pkg::ST_CHECK: begin
            first_in = 1'b0;
            case (op_ff)
               btmx_pkg::OP_INSERT: begin
                  if (cnt_b == '1) begin
                     status_in = btmx_pkg::STATUS_FULL;
                     state_in  = btmx_pkg::ST_DONE;
                  end else if (link_b == '0) begin
                     missing_in = btmx_pkg::CFG_W'(lvl_ff) + btmx_pkg::CFG_W'(1);
                     state_in   = btmx_pkg::ST_ROOM;
                  end else if (lvl_ff == '0) begin
                     state_in = btmx_pkg::ST_ROOM;
                  end else begin
                     nx = link_b;
                  end
               end
               btmx_pkg::OP_DELETE: begin
                  if (!hit) begin
                     status_in = btmx_pkg::STATUS_ABSENT;
                     state_in  = btmx_pkg::ST_DONE;
                  end else if (lvl_ff == '0) begin
                     state_in = btmx_pkg::ST_ROOM;
                  end else begin
                     nx = link_b;
                  end
               end
               btmx_pkg::OP_QUERY: begin
                  if (first_ff && eff.cnt0 == '0 && eff.cnt1 == '0) begin
                     status_in = btmx_pkg::STATUS_EMPTY;
                     state_in  = btmx_pkg::ST_DONE;
                  end else begin
                     if (hit) begin
                        partner_in[lvl_ff] = bit_b;
                        zmask_in[lvl_ff]   = !bit_b;
                        nx                 = link_b;
                     end else begin
                        partner_in[lvl_ff] = !bit_b;
                        nx                 = link_nb;
                     end
                     if (lvl_ff == '0) begin
                        state_in = btmx_pkg::ST_DONE;
                     end
                  end
               end
               default: begin
                  state_in = btmx_pkg::ST_DONE;
               end
            endcase
            if (state_in == btmx_pkg::ST_CHECK) begin
               cur_in      = nx;
               lvl_in      = lvl_ff - btmx_pkg::LVL_W'(1);
               mem_rd_en   = 1'b1;
               mem_rd_addr = nx;
            end
         end

         btmx_pkg::ST_ROOM: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = '0;
            cur_in      = '0;
            lvl_in      = top_lvl;
            fresh_in    = 1'b0;
            if (op_ff == btmx_pkg::OP_INSERT && need_sum > CAP_SUM) begin
               status_in = btmx_pkg::STATUS_FULL;
               state_in  = btmx_pkg::ST_DONE;
            end else begin
               state_in = btmx_pkg::ST_WRITE;
            end
         end

         btmx_pkg::ST_WRITE: begin
            mem_we = 1'b1;
            if (op_ff == btmx_pkg::OP_INSERT) begin
               root_valid_in = 1'b1;
               if (link_b == '0) begin
                  nx            = nodes_used_ff[NW-1:0];
                  nodes_used_in = nodes_used_ff + NUW'(1);
                  fresh_in      = 1'b1;
               end
               if (bit_b) begin
                  upd.link1 = nx;
                  upd.cnt1  = eff.cnt1 + COUNT_WIDTH'(1);
               end else begin
                  upd.link0 = nx;
                  upd.cnt0  = eff.cnt0 + COUNT_WIDTH'(1);
               end
            end else begin
               if (bit_b) begin
                  upd.cnt1 = eff.cnt1 - COUNT_WIDTH'(1);
               end else begin
                  upd.cnt0 = eff.cnt0 - COUNT_WIDTH'(1);
               end
            end
            if (lvl_ff == '0) begin
               state_in = btmx_pkg::ST_DONE;
            end else begin
               cur_in      = nx;
               lvl_in      = lvl_ff - btmx_pkg::LVL_W'(1);
               mem_rd_en   = 1'b1;
               mem_rd_addr = nx;
            end
         end

         btmx_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in   = 1'b1;
               rsp_partner_in = partner_ff;
               rsp_zmask_in   = zmask_ff;
               rsp_status_in  = status_ff;
               state_in       = btmx_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = btmx_pkg::ST_IDLE;
         end
      endcase
   end

   assign mem_wr_data        = upd;
   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.partner   = rsp_partner_ff;
   assign rsp_chan.zero_mask = rsp_zmask_ff;
   assign rsp_chan.status    = rsp_status_ff;

   a_nodes_bound: assert property (@(posedge clock) disable iff (reset)
      nodes_used_ff <= NUW'(NODE_CAPACITY))
      else $error("node count beyond capacity");

   a_mask_disjoint: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> ((rsp_chan.partner & rsp_chan.zero_mask) == '0))
      else $error("zero mask overlaps partner");

   a_fail_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.status != btmx_pkg::STATUS_OK)
         |-> (rsp_chan.partner == '0 && rsp_chan.zero_mask == '0))
      else $error("failed operation carries a payload");

   a_level_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == btmx_pkg::ST_CHECK || state_ff == btmx_pkg::ST_WRITE)
         |-> (btmx_pkg::CFG_W'(lvl_ff) < depth))
      else $error("walk level outside trie depth");

endmodule
